FILE: rtl/yuvpal_pkg.sv
package yuvpal_pkg;

    // Register map: byte address of each register
    localparam logic ADDR_ROW_BASE = 1'b0;

    // Conversion constants
    localparam logic        [16:0] LUMA_GAIN   = 17'd298;
    localparam logic        [7:0]  LUMA_FLOOR  = 8'd16;
    localparam logic signed [17:0] CR_TO_R     = 18'sd409;
    localparam logic signed [17:0] CB_TO_G     = 18'sd100;
    localparam logic signed [17:0] CR_TO_G     = 18'sd208;
    localparam logic signed [17:0] CB_TO_B     = 18'sd516;
    localparam logic signed [18:0] ROUND_HALF  = 19'sd128;
    localparam logic        [8:0]  CHROMA_ZERO = 9'd128;
    localparam logic        [7:0]  RED_STEP    = 8'd36;
    localparam logic        [7:0]  GREEN_STEP  = 8'd6;

    // Pipeline load enables handed to the lanes
    typedef struct packed {
        logic ld_a;
        logic ld_b;
    } yuvpal_ctl_t;

    // 4x4 ordered-dither threshold matrix
    function automatic logic [3:0] bayer(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] t;
        begin
            unique case ({row, col})
                4'h0: t = 4'd0;   4'h1: t = 4'd8;   4'h2: t = 4'd2;   4'h3: t = 4'd10;
                4'h4: t = 4'd12;  4'h5: t = 4'd4;   4'h6: t = 4'd14;  4'h7: t = 4'd6;
                4'h8: t = 4'd3;   4'h9: t = 4'd11;  4'hA: t = 4'd1;   4'hB: t = 4'd9;
                4'hC: t = 4'd15;  4'hD: t = 4'd7;   4'hE: t = 4'd13;  4'hF: t = 4'd5;
                default: t = 4'd0;
            endcase
            return t;
        end
    endfunction

    // trunc((t-8)*51/16)
    function automatic logic signed [5:0] dither_off(input logic [3:0] t);
        logic signed [5:0] o;
        begin
            unique case (t)
                4'd0:  o = -6'sd25;  4'd1:  o = -6'sd22;  4'd2:  o = -6'sd19;
                4'd3:  o = -6'sd15;  4'd4:  o = -6'sd12;  4'd5:  o = -6'sd9;
                4'd6:  o = -6'sd6;   4'd7:  o = -6'sd3;   4'd8:  o = 6'sd0;
                4'd9:  o = 6'sd3;    4'd10: o = 6'sd6;    4'd11: o = 6'sd9;
                4'd12: o = 6'sd12;   4'd13: o = 6'sd15;   4'd14: o = 6'sd19;
                4'd15: o = 6'sd22;
                default: o = 6'sd0;
            endcase
            return o;
        end
    endfunction

    // floor(sum/256) clipped to 0..255
    function automatic logic [7:0] shift_clip(input logic signed [18:0] sum);
        logic signed [18:0] s;
        logic [7:0]         v;
        begin
            s = sum >>> 8;
            if (s < 0)
                v = 8'd0;
            else if (s > 19'sd255)
                v = 8'd255;
            else
                v = s[7:0];
            return v;
        end
    endfunction

    // Add dither, clamp, quantize to six levels: (v*5+127)/255 via thresholds
    function automatic logic [2:0] dither_level(input logic [7:0] chan, input logic [3:0] t);
        logic signed [9:0] s;
        logic [7:0]        v;
        logic [2:0]        q;
        begin
            s = $signed({2'b00, chan}) + 10'(dither_off(t));
            if (s < 0)
                v = 8'd0;
            else if (s > 10'sd255)
                v = 8'd255;
            else
                v = s[7:0];
            if (v >= 8'd230)      q = 3'd5;
            else if (v >= 8'd179) q = 3'd4;
            else if (v >= 8'd128) q = 3'd3;
            else if (v >= 8'd77)  q = 3'd2;
            else if (v >= 8'd26)  q = 3'd1;
            else                  q = 3'd0;
            return q;
        end
    endfunction

endpackage

FILE: rtl/yuvpal_chroma.sv
module yuvpal_chroma
    import yuvpal_pkg::*;
(
    input  logic                clk,
    input  logic                ld_a,
    input  logic [7:0]          chroma_blue,
    input  logic [7:0]          chroma_red,
    output logic signed [17:0]  r_term,
    output logic signed [17:0]  g_term,
    output logic signed [17:0]  b_term
);

    logic signed [8:0]  d;
    logic signed [8:0]  e;
    logic signed [17:0] r_term_reg;
    logic signed [17:0] g_term_reg;
    logic signed [17:0] b_term_reg;

    assign d = $signed({1'b0, chroma_blue} - CHROMA_ZERO);
    assign e = $signed({1'b0, chroma_red} - CHROMA_ZERO);

    // shared chroma products, one set per word for both lanes
    always_ff @(posedge clk)
    begin
        if (ld_a)
        begin
            r_term_reg <= CR_TO_R * 18'(e);
            g_term_reg <= -(CB_TO_G * 18'(d)) - (CR_TO_G * 18'(e));
            b_term_reg <= CB_TO_B * 18'(d);
        end
    end

    assign r_term = r_term_reg;
    assign g_term = g_term_reg;
    assign b_term = b_term_reg;

endmodule

FILE: rtl/yuvpal_lane.sv
module yuvpal_lane
    import yuvpal_pkg::*;
(
    input  logic                clk,
    input  yuvpal_ctl_t         ctl,
    input  logic [7:0]          luma,
    input  logic [3:0]          thr,
    input  logic signed [17:0]  r_term,
    input  logic signed [17:0]  g_term,
    input  logic signed [17:0]  b_term,
    output logic [7:0]          index
);

    logic [7:0]         luma_off;
    logic [16:0]        c_a_reg;
    logic [3:0]         thr_a_reg;
    logic signed [18:0] c_ext;
    logic [7:0]         r_b_reg;
    logic [7:0]         g_b_reg;
    logic [7:0]         b_b_reg;
    logic [3:0]         thr_b_reg;
    logic [2:0]         q_r;
    logic [2:0]         q_g;
    logic [2:0]         q_b;

    // dark luma floors at 16
    assign luma_off = (luma >= LUMA_FLOOR) ? (luma - LUMA_FLOOR) : 8'd0;

    // stage A: luma product
    always_ff @(posedge clk)
    begin
        if (ctl.ld_a)
        begin
            c_a_reg   <= 17'(luma_off) * LUMA_GAIN;
            thr_a_reg <= thr;
        end
    end

    assign c_ext = $signed({2'b00, c_a_reg});

    // stage B: sum, round, shift, clip
    always_ff @(posedge clk)
    begin
        if (ctl.ld_b)
        begin
            r_b_reg   <= shift_clip(c_ext + 19'(r_term) + ROUND_HALF);
            g_b_reg   <= shift_clip(c_ext + 19'(g_term) + ROUND_HALF);
            b_b_reg   <= shift_clip(c_ext + 19'(b_term) + ROUND_HALF);
            thr_b_reg <= thr_a_reg;
        end
    end

    // dither and quantize, registered by the merge stage
    assign q_r   = dither_level(r_b_reg, thr_b_reg);
    assign q_g   = dither_level(g_b_reg, thr_b_reg);
    assign q_b   = dither_level(b_b_reg, thr_b_reg);
    assign index = 8'(q_r) * RED_STEP + 8'(q_g) * GREEN_STEP + 8'(q_b);

endmodule

FILE: rtl/yuv_to_dithered_palette_index.sv
// Channel  | Handshake                      | Payload
// ---------+--------------------------------+------------------------------------------
// input    | in_valid / in_stall            | luma_first, luma_second, chroma_blue,
//          |                                | chroma_red, has_second, column_phase, out_row
// output   | out_valid / out_stall          | first_index, second_index, second_valid
// config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata (row_base at 0)
//
// One word per clock sustained while out_stall stays low; three register stages (stage A,
// stage B, output register), and out_valid rises once a word reaches the output register.
// Pipeline: chroma/luma products, sum+clip, then dither/quantize into the output register.
// Each stage loads when it is empty or the stage after it moves, so bubbles collapse and
// input is taken while a finished word waits at the output.
// in_stall rises only when all three stages hold words and out_stall is high.
// rst_n (async, active low) empties the pipeline and clears row_base.
module yuv_to_dithered_palette_index
    import yuvpal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  luma_first,
    input  logic [7:0]  luma_second,
    input  logic [7:0]  chroma_blue,
    input  logic [7:0]  chroma_red,
    input  logic        has_second,
    input  logic [1:0]  column_phase,
    input  logic [1:0]  out_row,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  first_index,
    output logic [7:0]  second_index,
    output logic        second_valid,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        valid_a_reg;
    logic        valid_a_next;
    logic        valid_b_reg;
    logic        valid_b_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        ready_a;
    logic        ready_b;
    logic        ready_c;
    logic        ld_c;
    yuvpal_ctl_t ctl;

    logic [1:0]  row_base_reg;
    logic [1:0]  row;
    logic [3:0]  thr_first;
    logic [3:0]  thr_second;
    logic        has_a_reg;
    logic        has_b_reg;

    logic signed [17:0] r_term;
    logic signed [17:0] g_term;
    logic signed [17:0] b_term;
    logic [7:0]  idx_first;
    logic [7:0]  idx_second;

    logic [7:0]  first_index_reg;
    logic [7:0]  second_index_reg;
    logic        second_valid_reg;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ROW_BASE) ? {30'd0, row_base_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_base_reg <= 2'd0;
        else if (psel && penable && pwrite && pready && (paddr == ADDR_ROW_BASE))
            row_base_reg <= pwdata[1:0];
    end

    // ---------------- pipeline control ----------------
    assign ready_c = !out_valid_reg || !out_stall;
    assign ready_b = !valid_b_reg || ready_c;
    assign ready_a = !valid_a_reg || ready_b;

    assign ctl.ld_a = ready_a && in_valid;
    assign ctl.ld_b = ready_b && valid_a_reg;
    assign ld_c     = ready_c && valid_b_reg;

    assign valid_a_next   = ready_a ? in_valid    : valid_a_reg;
    assign valid_b_next   = ready_b ? valid_a_reg : valid_b_reg;
    assign out_valid_next = ready_c ? valid_b_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg   <= 1'b0;
            valid_b_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg   <= valid_a_next;
            valid_b_reg   <= valid_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = !ready_a;
    assign out_valid = out_valid_reg;

    // ---------------- dither thresholds ----------------
    // row offset wraps modulo four; the second pixel sits one column to the right
    assign row        = out_row + row_base_reg;
    assign thr_first  = bayer(row, column_phase);
    assign thr_second = bayer(row, column_phase + 2'd1);

    always_ff @(posedge clk)
    begin
        if (ctl.ld_a)
            has_a_reg <= has_second;
        if (ctl.ld_b)
            has_b_reg <= has_a_reg;
    end

    // ---------------- shared chroma and two pixel lanes ----------------
    yuvpal_chroma u_chroma (
        .clk         (clk),
        .ld_a        (ctl.ld_a),
        .chroma_blue (chroma_blue),
        .chroma_red  (chroma_red),
        .r_term      (r_term),
        .g_term      (g_term),
        .b_term      (b_term)
    );

    yuvpal_lane u_lane_first (
        .clk    (clk),
        .ctl    (ctl),
        .luma   (luma_first),
        .thr    (thr_first),
        .r_term (r_term),
        .g_term (g_term),
        .b_term (b_term),
        .index  (idx_first)
    );

    yuvpal_lane u_lane_second (
        .clk    (clk),
        .ctl    (ctl),
        .luma   (luma_second),
        .thr    (thr_second),
        .r_term (r_term),
        .g_term (g_term),
        .b_term (b_term),
        .index  (idx_second)
    );

    // ---------------- merge / output register ----------------
    // odd-width row tail: second pixel forced to zero and flagged invalid
    always_ff @(posedge clk)
    begin
        if (ld_c)
        begin
            first_index_reg  <= idx_first;
            second_index_reg <= has_b_reg ? idx_second : 8'd0;
            second_valid_reg <= has_b_reg;
        end
    end

    assign first_index  = first_index_reg;
    assign second_index = second_index_reg;
    assign second_valid = second_valid_reg;

endmodule

FILE: rtl/yuvpal_checker.sv
module yuvpal_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] first_index,
    input logic [7:0] second_index,
    input logic       second_valid
);

    // a stalled word stays presented
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    // input only backs up behind a stalled, full output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // missing second pixel reads as zero
    a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !second_valid |-> second_index == 8'd0)
        else $error("second_index nonzero on row tail");

    // palette has 216 entries
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (first_index <= 8'd215) && (second_index <= 8'd215))
        else $error("palette index out of range");

endmodule

bind yuv_to_dithered_palette_index yuvpal_checker u_yuvpal_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .first_index  (first_index),
    .second_index (second_index),
    .second_valid (second_valid)
);

FILE: tb/tb_yuv_to_dithered_palette_index.sv
module tb_yuv_to_dithered_palette_index
    import yuvpal_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Generous cycle budget: ~1000 words, each with random idle gaps on the
    // send side and random stalls on the receive side, plus register traffic
    // and drain time.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PIPE_LATENCY = 3;
    localparam int WORDS_PER_PHASE = 250;

    // Ordered-dither threshold matrix, indexed [row][column]
    localparam int THRESH_MAP [4][4] = '{
        '{ 0,  8,  2, 10},
        '{12,  4, 14,  6},
        '{ 3, 11,  1,  9},
        '{15,  7, 13,  5}
    };

    typedef struct {
        logic [7:0] y0;
        logic [7:0] y1;
        logic [7:0] cb;
        logic [7:0] cr;
        logic       has2;
        logic [1:0] phase;
        logic [1:0] row;
    } pixel_pair_t;

    typedef struct {
        logic [7:0] idx0;
        logic [7:0] idx1;
        logic       valid1;
    } palette_pair_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  luma_first;
    logic [7:0]  luma_second;
    logic [7:0]  chroma_blue;
    logic [7:0]  chroma_red;
    logic        has_second;
    logic [1:0]  column_phase;
    logic [1:0]  out_row;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  first_index;
    logic [7:0]  second_index;
    logic        second_valid;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic        paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the row_base register, kept in step with every APB write
    logic [1:0]     row_base_shadow;
    // Palette pairs the block still owes us, oldest first
    palette_pair_t  owed_pairs[$];
    int             error_count;
    int             words_sent;
    int             words_checked;
    int             reg_writes;
    // Idle knobs: when clear, that side runs flat out
    bit             send_gaps_on;
    bit             recv_stalls_on;

    yuv_to_dithered_palette_index u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .luma_first   (luma_first),
        .luma_second  (luma_second),
        .chroma_blue  (chroma_blue),
        .chroma_red   (chroma_red),
        .has_second   (has_second),
        .column_phase (column_phase),
        .out_row      (out_row),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .first_index  (first_index),
        .second_index (second_index),
        .second_valid (second_valid),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int clip_byte(input int v);
        if (v < 0)
            return 0;
        if (v > 255)
            return 255;
        return v;
    endfunction

    // Add the ordered-dither offset for threshold t, then quantize to six levels.
    // Offset is (t-8)*51/16 truncated toward zero, which SV int division does.
    function automatic int six_level(input int chan, input int t);
        int v;
        v = clip_byte(chan + ((t - 8) * 51) / 16);
        return (v * 5 + 127) / 255;
    endfunction

    // BT.601 integer YCbCr -> RGB, dither, and pack into a 6x6x6 palette index.
    // d = Cb-128, e = Cr-128. The >>> on a signed int is a floor division by 256.
    function automatic logic [7:0] dithered_index(input logic [7:0] y, input int d,
                                                  input int e, input int t);
        int l;
        int c;
        int r;
        int g;
        int b;
        l = int'(y) - 16;
        if (l < 0)
            l = 0;
        c = 298 * l;
        r = clip_byte((c + 409 * e + 128) >>> 8);
        g = clip_byte((c - 100 * d - 208 * e + 128) >>> 8);
        b = clip_byte((c + 516 * d + 128) >>> 8);
        return 8'(36 * six_level(r, t) + 6 * six_level(g, t) + six_level(b, t));
    endfunction

    function automatic palette_pair_t predict_palette_pair(input pixel_pair_t p,
                                                           input logic [1:0] rbase);
        palette_pair_t res;
        logic [1:0]    mrow;
        logic [1:0]    next_phase;
        int            d;
        int            e;
        mrow       = p.row + rbase;
        next_phase = p.phase + 2'd1;
        d          = int'(p.cb) - 128;
        e          = int'(p.cr) - 128;
        res.idx0   = dithered_index(p.y0, d, e, THRESH_MAP[mrow][p.phase]);
        // Odd-width row tail: second pixel reported as zero and not valid
        if (p.has2)
        begin
            res.idx1   = dithered_index(p.y1, d, e, THRESH_MAP[mrow][next_phase]);
            res.valid1 = 1'b1;
        end
        else
        begin
            res.idx1   = 8'd0;
            res.valid1 = 1'b0;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Input side: one word per call, valid held high across back-to-back words
    // ------------------------------------------------------------------

    task automatic send_pair(input pixel_pair_t p);
        int gap;
        @(negedge clk);
        luma_first   <= p.y0;
        luma_second  <= p.y1;
        chroma_blue  <= p.cb;
        chroma_red   <= p.cr;
        has_second   <= p.has2;
        column_phase <= p.phase;
        out_row      <= p.row;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        owed_pairs.push_back(predict_palette_pair(p, row_base_shadow));
        words_sent++;
        // Idle gap after the word; with zero gap the next call keeps valid high
        gap = send_gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Block is idle once every owed pair has come back and the pipe has flushed
    task automatic wait_drained();
        while (owed_pairs.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // APB register access (setup cycle, then access cycle)
    // ------------------------------------------------------------------

    task automatic apb_write(input logic addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_ROW_BASE)
            row_base_shadow = data[1:0];
        reg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check_row_base();
        logic [31:0] want;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_ROW_BASE;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        want = {30'd0, row_base_shadow};
        if (prdata !== want)
        begin
            $display("%0t: row_base readback mismatch: expected %0d, got %0d",
                     $time, want, prdata);
            error_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Change row_base only with the pipeline empty; upper data bits are junk
    task automatic set_row_base(input logic [1:0] rb);
        wait_drained();
        apb_write(ADDR_ROW_BASE, {30'($urandom_range(0, 32'h3FFF_FFFF)), rb});
        apb_check_row_base();
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls per word, and the checker
    // ------------------------------------------------------------------

    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = recv_stalls_on ? $urandom_range(0, 4) : 0;
            if (n > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    initial
    begin
        palette_pair_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (owed_pairs.size() == 0)
                begin
                    $display("%0t: word out with nothing owed: %0d %0d %0d",
                             $time, first_index, second_index, second_valid);
                    error_count++;
                end
                else
                begin
                    want = owed_pairs.pop_front();
                    words_checked++;
                    if (first_index !== want.idx0)
                    begin
                        $display("%0t: first_index expected %0d, got %0d",
                                 $time, want.idx0, first_index);
                        error_count++;
                    end
                    if (second_index !== want.idx1)
                    begin
                        $display("%0t: second_index expected %0d, got %0d",
                                 $time, want.idx1, second_index);
                        error_count++;
                    end
                    if (second_valid !== want.valid1)
                    begin
                        $display("%0t: second_valid expected %0d, got %0d",
                                 $time, want.valid1, second_valid);
                        error_count++;
                    end
                end
            end
        end
    end

    // Hard stop if the block hangs
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles, %0d pair(s) still owed",
                 CYCLE_LIMIT, owed_pairs.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic pixel_pair_t make_pair(input int y0, input int y1, input int cb,
                                              input int cr, input int has2,
                                              input int phase, input int row);
        pixel_pair_t p;
        p.y0    = 8'(y0);
        p.y1    = 8'(y1);
        p.cb    = 8'(cb);
        p.cr    = 8'(cr);
        p.has2  = 1'(has2);
        p.phase = 2'(phase);
        p.row   = 2'(row);
        return p;
    endfunction

    // Mostly uniform, with a slice of the values where clamps and clips bite
    function automatic logic [7:0] pick_sample();
        logic [7:0] edges [8] = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17, 8'd235, 8'd254, 8'd255};
        if ($urandom_range(0, 7) == 0)
            return edges[$urandom_range(0, 7)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic pixel_pair_t random_pair();
        pixel_pair_t p;
        p.y0    = pick_sample();
        p.y1    = pick_sample();
        p.cb    = pick_sample();
        p.cr    = pick_sample();
        // Row tails are a minority, as in real frames
        p.has2  = ($urandom_range(0, 5) != 0);
        p.phase = 2'($urandom_range(0, 3));
        p.row   = 2'($urandom_range(0, 3));
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset value, then every row_base value written and read back
    task automatic test_row_base_register();
        apb_check_row_base();
        for (int rb = 0; rb < 4; rb++)
            set_row_base(2'(rb));
        set_row_base(2'd0);
    endtask

    // Clamp corners, odd-width tails, and every dither row/column position
    task automatic test_directed_pairs();
        send_gaps_on   = 1'b0;
        recv_stalls_on = 1'b0;
        // Dark luma below the floor, and full white
        send_pair(make_pair(0, 255, 128, 128, 1, 0, 0));
        send_pair(make_pair(15, 16, 128, 128, 1, 1, 1));
        // Chroma at both extremes, saturating every channel both ways
        send_pair(make_pair(235, 255, 0, 0, 1, 2, 2));
        send_pair(make_pair(255, 255, 255, 255, 1, 3, 3));
        send_pair(make_pair(0, 0, 0, 255, 1, 3, 0));
        send_pair(make_pair(255, 0, 255, 0, 1, 2, 1));
        // Missing second pixel: luma_second must not leak through
        send_pair(make_pair(128, 255, 128, 128, 0, 1, 2));
        send_pair(make_pair(200, 0, 60, 200, 0, 3, 3));
        // Walk the whole 4x4 threshold matrix, phase 3 wraps the second pixel to 0
        for (int r = 0; r < 4; r++)
            for (int ph = 0; ph < 4; ph++)
                send_pair(make_pair(128, 130, 100, 160, 1, ph, r));
        stop_sending();
    endtask

    // Random words under one row_base, with a chosen idle pattern
    task automatic test_random_pairs(input logic [1:0] rb, input bit gaps,
                                     input bit stalls);
        set_row_base(rb);
        send_gaps_on   = gaps;
        recv_stalls_on = stalls;
        repeat (WORDS_PER_PHASE)
        begin
            // Occasionally flip idling on either side mid-stream
            if ($urandom_range(0, 63) == 0)
                send_gaps_on = ~send_gaps_on;
            if ($urandom_range(0, 63) == 0)
                recv_stalls_on = ~recv_stalls_on;
            send_pair(random_pair());
        end
        stop_sending();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        luma_first      = 8'd0;
        luma_second     = 8'd0;
        chroma_blue     = 8'd0;
        chroma_red      = 8'd0;
        has_second      = 1'b0;
        column_phase    = 2'd0;
        out_row         = 2'd0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = 1'b0;
        pwdata          = 32'd0;
        row_base_shadow = 2'd0;
        error_count     = 0;
        words_sent      = 0;
        words_checked   = 0;
        reg_writes      = 0;
        send_gaps_on    = 1'b0;
        recv_stalls_on  = 1'b0;

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_row_base_register();
        test_directed_pairs();
        test_random_pairs(2'd0, 1'b1, 1'b1);
        test_random_pairs(2'd3, 1'b0, 1'b0);
        test_random_pairs(2'd1, 1'b1, 1'b0);
        test_random_pairs(2'd2, 1'b0, 1'b1);

        wait_drained();
        repeat (2 * PIPE_LATENCY) @(posedge clk);

        $display("Sent %0d pixel-pair words, checked %0d palette results", words_sent,
                 words_checked);
        $display("Covered row_base 0..3 over %0d register writes, with and without idling",
                 reg_writes);
        if (error_count == 0 && owed_pairs.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
rtl/yuvpal_pkg.sv
rtl/yuvpal_chroma.sv
rtl/yuvpal_lane.sv
rtl/yuv_to_dithered_palette_index.sv
rtl/yuvpal_checker.sv
tb/tb_yuv_to_dithered_palette_index.sv
